// ===== src/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// Request codes and field widths shared by the timeout slot pool.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int REQ_W   = 2;
  localparam int COUNT_W = 16;
  localparam int SEL_W   = 3;
  localparam int GRANT_W = 3;
  localparam int MASK_W  = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

endpackage

// ===== src/tsp_free_search.sv =====
// ----------------------------------------------------------------------------
// tsp_free_search
// Priority encoder that finds the lowest-numbered free slot in the pool.
// ----------------------------------------------------------------------------
module tsp_free_search #(
  parameter int SLOT_COUNT = 8,
  parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic [SLOT_COUNT-1:0] slot_busy,
  output logic                  found,
  output logic [IDX_W-1:0]      found_idx
);

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (!slot_busy[s]) begin
        found     = 1'b1;
        found_idx = IDX_W'(s);
      end
    end
  end

endmodule

// ===== src/timeout_slot_pool.sv =====
// ----------------------------------------------------------------------------
// timeout_slot_pool
// Pool of countdown timeout slots: allocate the lowest free slot, tick all
// busy slots down to zero, clear a named slot. Each word returns the grant
// and the mask of busy slots that have reached zero.
//
//   channel   handshake          fields
//   -------   ----------------   ------------------------------------------
//   request   start / busy       req_type, start_count, slot_select
//   result    done (strobe)      granted_slot, grant_ok, expired_mask
//
// A request word is registered on acceptance and applied to the slot state
// in the next cycle, which also loads the result register and raises done
// with it; the receiver takes the result word while done is high. busy
// stays low, so a word is taken every cycle and the sustained rate is one
// word per cycle. The slot state update is the single loop that sets this
// figure. Reset (rst, synchronous) frees all slots and zeroes all counts.
// The receiver cannot stall the results.
// ----------------------------------------------------------------------------
module timeout_slot_pool #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [tsp_pkg::REQ_W-1:0]   req_type,
  input  logic [tsp_pkg::COUNT_W-1:0] start_count,
  input  logic [tsp_pkg::SEL_W-1:0]   slot_select,
  output logic                        done,
  output logic [tsp_pkg::GRANT_W-1:0] granted_slot,
  output logic                        grant_ok,
  output logic [tsp_pkg::MASK_W-1:0]  expired_mask
);

  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MASK_SLOTS = (SLOT_COUNT < tsp_pkg::MASK_W) ? SLOT_COUNT
                                                             : tsp_pkg::MASK_W;

  logic                        in_valid;
  logic [tsp_pkg::REQ_W-1:0]   in_type;
  logic [tsp_pkg::COUNT_W-1:0] in_count;
  logic [tsp_pkg::SEL_W-1:0]   in_sel;

  logic [SLOT_COUNT-1:0]       slot_busy;
  logic [SLOT_COUNT-1:0]       slot_busy_next;
  logic [tsp_pkg::COUNT_W-1:0] slot_count      [SLOT_COUNT];
  logic [tsp_pkg::COUNT_W-1:0] slot_count_next [SLOT_COUNT];

  logic                        found;
  logic [IDX_W-1:0]            found_idx;

  logic [tsp_pkg::GRANT_W-1:0] granted_next;
  logic                        grant_ok_next;
  logic [tsp_pkg::MASK_W-1:0]  mask_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_type  <= req_type;
      in_count <= start_count;
      in_sel   <= slot_select;
    end
  end

  tsp_free_search #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_free_search (
    .slot_busy (slot_busy),
    .found     (found),
    .found_idx (found_idx)
  );

  always_comb begin
    slot_busy_next = slot_busy;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      slot_count_next[s] = slot_count[s];
    end
    granted_next  = '0;
    grant_ok_next = 1'b0;
    if (in_valid) begin
      case (in_type)
        tsp_pkg::REQ_ALLOC: begin
          if (found) begin
            granted_next  = tsp_pkg::GRANT_W'(found_idx);
            grant_ok_next = 1'b1;
            for (int s = 0; s < SLOT_COUNT; s++) begin
              if (found_idx == IDX_W'(s)) begin
                slot_busy_next[s]  = 1'b1;
                slot_count_next[s] = in_count;
              end
            end
          end
        end
        tsp_pkg::REQ_TICK: begin
          for (int s = 0; s < SLOT_COUNT; s++) begin
            if (slot_busy[s] && (slot_count[s] != '0)) begin
              slot_count_next[s] = slot_count[s] - tsp_pkg::COUNT_W'(1);
            end
          end
        end
        tsp_pkg::REQ_CLEAR: begin
          for (int s = 0; s < SLOT_COUNT; s++) begin
            if (32'(in_sel) == s) begin
              slot_busy_next[s]  = 1'b0;
              slot_count_next[s] = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mask_next = '0;
    for (int s = 0; s < MASK_SLOTS; s++) begin
      mask_next[s] = slot_busy_next[s] && (slot_count_next[s] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy <= '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        slot_count[s] <= '0;
      end
      done <= 1'b0;
    end else begin
      slot_busy <= slot_busy_next;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        slot_count[s] <= slot_count_next[s];
      end
      done <= in_valid;
    end
    if (in_valid) begin
      granted_slot <= granted_next;
      grant_ok     <= grant_ok_next;
      expired_mask <= mask_next;
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timeout slot pool. Drives allocate, tick, clear
// and unused request words through the start/busy handshake, predicts each
// result word from a private copy of the slot state, and compares every done
// strobe field by field against the oldest prediction. Runs a directed
// sequence (zero and full counts, pool full, clear of a free slot, unused
// code) followed by random traffic under several sender idling profiles.
// ----------------------------------------------------------------------------
module tb;

  localparam int SLOTS = 8;
  localparam logic [tsp_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [tsp_pkg::GRANT_W-1:0] slot;
    logic                        ok;
    logic [tsp_pkg::MASK_W-1:0]  mask;
  } grant_word_t;

  class slot_pool_scoreboard;
    bit                          slot_held[SLOTS];
    logic [tsp_pkg::COUNT_W-1:0] slot_left[SLOTS];
    grant_word_t                 grant_q[$];
    int errors;
    int n_words, n_grants, n_full, n_ticks, n_clears, n_unused, n_expired;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        slot_held[s] = 1'b0;
        slot_left[s] = '0;
      end
      errors = 0;
      n_words = 0; n_grants = 0; n_full = 0; n_ticks = 0;
      n_clears = 0; n_unused = 0; n_expired = 0;
    endfunction

    function void note_word(logic [tsp_pkg::REQ_W-1:0] req,
                            logic [tsp_pkg::COUNT_W-1:0] cnt,
                            logic [tsp_pkg::SEL_W-1:0] sel);
      grant_word_t w;
      bit found;
      w = '0;
      found = 1'b0;
      n_words++;
      case (req)
        tsp_pkg::REQ_ALLOC: begin
          for (int s = 0; s < SLOTS; s++) begin
            if (!found && !slot_held[s]) begin
              found = 1'b1;
              slot_held[s] = 1'b1;
              slot_left[s] = cnt;
              w.slot = s[tsp_pkg::GRANT_W-1:0];
              w.ok = 1'b1;
            end
          end
          if (found) n_grants++;
          else n_full++;
        end
        tsp_pkg::REQ_TICK: begin
          n_ticks++;
          for (int s = 0; s < SLOTS; s++)
            if (slot_held[s] && slot_left[s] != '0) slot_left[s] = slot_left[s] - 1'b1;
        end
        tsp_pkg::REQ_CLEAR: begin
          n_clears++;
          if (int'(sel) < SLOTS) begin
            slot_held[sel] = 1'b0;
            slot_left[sel] = '0;
          end
        end
        default: n_unused++;
      endcase
      for (int s = 0; s < SLOTS && s < tsp_pkg::MASK_W; s++)
        if (slot_held[s] && slot_left[s] == '0) w.mask[s] = 1'b1;
      if (w.mask != '0) n_expired++;
      grant_q.push_back(w);
    endfunction

    function void check_word(logic [tsp_pkg::GRANT_W-1:0] slot, logic ok,
                             logic [tsp_pkg::MASK_W-1:0] mask);
      grant_word_t w;
      if (grant_q.size() == 0) begin
        $error("result word with no prediction pending: slot=%0d ok=%0b mask=%02h",
               slot, ok, mask);
        errors++;
        return;
      end
      w = grant_q.pop_front();
      if (slot !== w.slot) begin
        $error("granted_slot: expected %0d, actual %0d", w.slot, slot);
        errors++;
      end
      if (ok !== w.ok) begin
        $error("grant_ok: expected %0b, actual %0b", w.ok, ok);
        errors++;
      end
      if (mask !== w.mask) begin
        $error("expired_mask: expected %02h, actual %02h", w.mask, mask);
        errors++;
      end
    endfunction

    function int pending();
      return grant_q.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic [tsp_pkg::REQ_W-1:0]    req_type = '0;
  logic [tsp_pkg::COUNT_W-1:0]  start_count = '0;
  logic [tsp_pkg::SEL_W-1:0]    slot_select = '0;
  logic                         done;
  logic [tsp_pkg::GRANT_W-1:0]  granted_slot;
  logic                         grant_ok;
  logic [tsp_pkg::MASK_W-1:0]   expired_mask;

  slot_pool_scoreboard sb = new();

  timeout_slot_pool #(.SLOT_COUNT(SLOTS)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .start_count  (start_count),
    .slot_select  (slot_select),
    .done         (done),
    .granted_slot (granted_slot),
    .grant_ok     (grant_ok),
    .expired_mask (expired_mask)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_word(granted_slot, grant_ok, expired_mask);
      if (start && !busy) sb.note_word(req_type, start_count, slot_select);
    end
  end

  task automatic send_word(input logic [tsp_pkg::REQ_W-1:0] req,
                           input logic [tsp_pkg::COUNT_W-1:0] cnt,
                           input logic [tsp_pkg::SEL_W-1:0] sel);
    start       <= 1'b1;
    req_type    <= req;
    start_count <= cnt;
    slot_select <= sel;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_idle(input int pct);
    while ($urandom_range(99) < pct) begin
      start       <= 1'b0;
      req_type    <= 2'($urandom_range(3));
      start_count <= 16'($urandom);
      slot_select <= 3'($urandom_range(7));
      @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [tsp_pkg::REQ_W-1:0]   req;
    logic [tsp_pkg::COUNT_W-1:0] cnt;
    int pick;
    pick = $urandom_range(99);
    if (pick < 36) req = tsp_pkg::REQ_ALLOC;
    else if (pick < 70) req = tsp_pkg::REQ_TICK;
    else if (pick < 95) req = tsp_pkg::REQ_CLEAR;
    else req = REQ_UNUSED;
    pick = $urandom_range(99);
    if (pick < 70) cnt = 16'($urandom_range(6));
    else if (pick < 90) cnt = 16'($urandom_range(40));
    else cnt = 16'($urandom);
    send_word(req, cnt, 3'($urandom_range(7)));
  endtask

  task automatic run_directed();
    send_word(tsp_pkg::REQ_ALLOC, 16'h0000, 3'd0);
    send_word(tsp_pkg::REQ_ALLOC, 16'hFFFF, 3'd7);
    send_word(tsp_pkg::REQ_ALLOC, 16'd1, 3'd0);
    send_word(tsp_pkg::REQ_ALLOC, 16'd2, 3'd0);
    send_word(tsp_pkg::REQ_ALLOC, 16'd3, 3'd0);
    send_word(tsp_pkg::REQ_ALLOC, 16'd4, 3'd0);
    send_word(tsp_pkg::REQ_ALLOC, 16'd5, 3'd0);
    send_word(tsp_pkg::REQ_ALLOC, 16'd6, 3'd0);
    send_word(tsp_pkg::REQ_ALLOC, 16'd7, 3'd7);
    send_word(tsp_pkg::REQ_TICK, 16'hFFFF, 3'd7);
    send_word(tsp_pkg::REQ_TICK, 16'h0000, 3'd0);
    send_word(tsp_pkg::REQ_TICK, 16'h1234, 3'd5);
    send_word(tsp_pkg::REQ_CLEAR, 16'h0000, 3'd0);
    send_word(tsp_pkg::REQ_CLEAR, 16'hFFFF, 3'd0);
    send_word(tsp_pkg::REQ_ALLOC, 16'hAAAA, 3'd2);
    send_word(REQ_UNUSED, 16'h0000, 3'd0);
    send_word(tsp_pkg::REQ_CLEAR, 16'h0000, 3'd7);
    send_word(tsp_pkg::REQ_CLEAR, 16'h0000, 3'd1);
    send_word(tsp_pkg::REQ_ALLOC, 16'h5555, 3'd5);
    send_word(tsp_pkg::REQ_TICK, 16'h0000, 3'd0);
    send_word(tsp_pkg::REQ_CLEAR, 16'h0000, 3'd7);
    send_word(REQ_UNUSED, 16'hFFFF, 3'd7);
    send_word(tsp_pkg::REQ_ALLOC, 16'd0, 3'd0);
  endtask

  initial begin
    int idle_pct[3];
    int guard;
    idle_pct[0] = 0;
    idle_pct[1] = 63;
    idle_pct[2] = 20;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < 550; i++) begin
        hold_idle(idle_pct[p]);
        send_random();
      end
    end
    start <= 1'b0;
    guard = 0;
    while (sb.pending() > 0 && guard < 100) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (sb.pending() > 0) begin
      $error("%0d predicted result words never arrived", sb.pending());
      sb.errors++;
    end
    $display("Run covered %0d words: %0d grants, %0d on a full pool, %0d ticks, %0d clears,",
             sb.n_words, sb.n_grants, sb.n_full, sb.n_ticks, sb.n_clears);
    $display("%0d unused codes; %0d results carried expired slots; %0d errors.",
             sb.n_unused, sb.n_expired, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
src/tsp_pkg.sv
src/tsp_free_search.sv
src/timeout_slot_pool.sv
verif/tb.sv
